### rtl/core/scmask_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Soft circle alpha mask package
// Shared widths, transfer structs, register indexes and the structs that
// travel between the pipeline stages and the cell chains.
// ---------------------------------------------------------------------------
package scmask_pkg;

   // Field widths of the transfers and the registers.
   localparam int COL_W   = 10;
   localparam int DIAM_W  = 11;
   localparam int SOFT_W  = 9;
   localparam int ALPHA_W = 8;

   // Largest diameter the mask supports; larger register values saturate.
   localparam int MAX_DIAMETER = 1024;
   localparam int DIAM_LIMIT   = (MAX_DIAMETER < (1 << DIAM_W) - 1) ?
                                 MAX_DIAMETER : (1 << DIAM_W) - 1;

   // Softness of one in Q1.8, and the one-pixel bias in half-pixel Q8 units.
   localparam int SOFT_ONE  = 256;
   localparam int SOFT_BIAS = 512;

   // Reset values of the registers.
   localparam logic [DIAM_W-1:0] DIAM_RESET = DIAM_W'(64);
   localparam logic [SOFT_W-1:0] SOFT_RESET = SOFT_W'(128);

   // Datapath widths.
   localparam int SQ_W       = 2 * DIAM_W;          // one squared offset
   localparam int SUM_W      = SQ_W + 1;            // sum of two squares
   localparam int FRAC_SHIFT = 16;                  // 8 fraction bits of the root
   localparam int ROOT_W     = 20;                  // distance, Q8 half pixels
   localparam int RAD_W      = 2 * ROOT_W;          // radicand
   localparam int REM_W      = ROOT_W + 2;          // square root remainder
   localparam int START_W    = SOFT_W + DIAM_W;     // soft start
   localparam int LEN_W      = START_W + 1;         // signed soft length
   localparam int DIVISOR_W  = START_W;             // positive soft length
   localparam int NUM_W      = DIVISOR_W + ALPHA_W; // 255 times the distance left

   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = '1;
   localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = '0;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = 1;
   localparam logic [REG_IDX_W-1:0] REG_DIAMETER = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_SOFTNESS = 1'b1;

   // Transfer payloads.
   typedef struct packed {
      logic [COL_W-1:0] pixel_column;
      logic [COL_W-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha_value;
      logic               outside_mask;
   } rsp_type;

   // Values derived from the registers.
   typedef struct packed {
      logic [DIAM_W-1:0]       diameter;
      logic [START_W-1:0]      start;
      logic signed [LEN_W-1:0] len;
   } cfg_type;

   // Data that walks through the square root cells.
   typedef struct packed {
      logic              outside;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_stage_type;

   // Result known before the division, carried alongside it.
   typedef struct packed {
      logic               outside;
      logic               fixed;
      logic [ALPHA_W-1:0] fixed_alpha;
   } div_side_type;

   // Data that walks through the division cells.
   typedef struct packed {
      div_side_type         side;
      logic [DIVISOR_W-1:0] part;
      logic [ALPHA_W-1:0]   shift;
   } div_stage_type;

endpackage
`default_nettype wire

### rtl/core/soft_circle_alpha_mask.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Soft circle alpha mask
// Alpha value of one pixel of a square soft-brush mask per transfer.
//
//   Channel  Ports                         Direction  Carries
//   req      req_valid/req_ready/req_data  in         pixel column and row
//   rsp      rsp_valid/rsp_ready/rsp_data  out        alpha value, outside flag
//   csr      psel/penable/pwrite/paddr...  in/out     diameter, softness
//
// One pixel is taken per cycle while req_ready is high. The depth of the
// pipeline is set mainly by the 20 square root cells and the 8 division
// cells. Reset clears all valid bits and loads diameter 64 and softness
// 128. A stalled output fills the skid entry, after which req_ready drops
// and the whole pipeline holds until the output is taken.
// ---------------------------------------------------------------------------
module soft_circle_alpha_mask (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire scmask_pkg::req_type                 req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output scmask_pkg::rsp_type                      rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [scmask_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [scmask_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [scmask_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                     pready
);
   import scmask_pkg::*;

   cfg_type cfg;
   logic    en;

   // Input stage.
   logic    a_valid_ff;
   req_type a_req_ff;

   // Offsets from the center.
   logic              b_valid_ff;
   logic              b_outside_ff, b_outside_in;
   logic [DIAM_W-1:0] b_dx_ff, b_dx_in;
   logic [DIAM_W-1:0] b_dy_ff, b_dy_in;
   logic [DIAM_W-1:0] col2;
   logic [DIAM_W-1:0] row2;

   // Squares.
   logic            c_valid_ff;
   logic            c_outside_ff;
   logic [SQ_W-1:0] c_dxsq_ff, c_dxsq_in;
   logic [SQ_W-1:0] c_dysq_ff, c_dysq_in;

   // Radicand, head of the square root chain.
   logic             d_valid_ff;
   sq_stage_type     d_stage_ff, d_stage_in;
   logic [SUM_W-1:0] sum;

   logic         sq_valid [ROOT_W+1];
   sq_stage_type sq_stage [ROOT_W+1];

   // Distance against the soft start.
   logic               e_valid_ff;
   logic               e_outside_ff;
   logic               e_inner_ff, e_inner_in;
   logic [ROOT_W-1:0]  e_excess_ff, e_excess_in;
   logic [ROOT_W-1:0]  dist_q8;

   // Case selection and distance left in the soft band.
   logic                 f_valid_ff;
   div_side_type         f_side_ff, f_side_in;
   logic [DIVISOR_W-1:0] f_diff_ff, f_diff_in;

   // Dividend, head of the division chain.
   logic             g_valid_ff;
   div_stage_type    g_stage_ff, g_stage_in;
   logic [NUM_W-1:0] numer;

   logic          dv_valid [ALPHA_W+1];
   div_stage_type dv_stage [ALPHA_W+1];

   rsp_type result;

   assign req_ready = en;

   // Configuration registers.
   scmask_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Offsets in half pixels and the outside test.
   always_comb begin
      col2         = {a_req_ff.pixel_column, 1'b0};
      row2         = {a_req_ff.pixel_row, 1'b0};
      b_outside_in = ({1'b0, a_req_ff.pixel_column} >= cfg.diameter) ||
                     ({1'b0, a_req_ff.pixel_row} >= cfg.diameter);
      b_dx_in      = (col2 >= cfg.diameter) ? col2 - cfg.diameter : cfg.diameter - col2;
      b_dy_in      = (row2 >= cfg.diameter) ? row2 - cfg.diameter : cfg.diameter - row2;
   end

   // Squared offsets.
   always_comb begin
      c_dxsq_in = SQ_W'(b_dx_ff) * SQ_W'(b_dx_ff);
      c_dysq_in = SQ_W'(b_dy_ff) * SQ_W'(b_dy_ff);
   end

   // Sum of squares scaled for eight fraction bits of the root.
   always_comb begin
      sum                = SUM_W'(c_dxsq_ff) + SUM_W'(c_dysq_ff);
      d_stage_in.outside = c_outside_ff;
      d_stage_in.rad     = RAD_W'({sum, {FRAC_SHIFT{1'b0}}});
      d_stage_in.rem     = '0;
      d_stage_in.root    = '0;
   end

   // Square root chain, one root bit per cell.
   assign sq_valid[0] = d_valid_ff;
   assign sq_stage[0] = d_stage_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      scmask_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (sq_valid[i]),
         .stage_in  (sq_stage[i]),
         .valid_out (sq_valid[i+1]),
         .stage_out (sq_stage[i+1])
      );
   end

   // Distance beyond the fully opaque disc.
   always_comb begin
      dist_q8     = sq_stage[ROOT_W].root;
      e_inner_in  = (dist_q8 <= cfg.start);
      e_excess_in = dist_q8 - cfg.start;
   end

   // Results that need no division are settled here.
   always_comb begin
      f_side_in.outside     = e_outside_ff;
      f_side_in.fixed       = 1'b1;
      f_side_in.fixed_alpha = ALPHA_CLEAR;
      f_diff_in             = '0;
      if (e_outside_ff) begin
         f_side_in.fixed_alpha = ALPHA_CLEAR;
      end else if (e_inner_ff) begin
         f_side_in.fixed_alpha = ALPHA_OPAQUE;
      end else if (cfg.len == '0) begin
         f_side_in.fixed_alpha = ALPHA_CLEAR;
      end else if (cfg.len[LEN_W-1]) begin
         f_side_in.fixed_alpha = ALPHA_OPAQUE;
      end else if (e_excess_ff >= cfg.len[DIVISOR_W-1:0]) begin
         f_side_in.fixed_alpha = ALPHA_CLEAR;
      end else begin
         f_side_in.fixed = 1'b0;
         f_diff_in       = cfg.len[DIVISOR_W-1:0] - e_excess_ff;
      end
   end

   // Dividend 255 times the distance left, split into remainder and bits.
   always_comb begin
      numer            = NUM_W'({f_diff_ff, {ALPHA_W{1'b0}}}) - NUM_W'(f_diff_ff);
      g_stage_in.side  = f_side_ff;
      g_stage_in.part  = numer[NUM_W-1 -: DIVISOR_W];
      g_stage_in.shift = numer[ALPHA_W-1:0];
   end

   // Division chain, one quotient bit per cell.
   assign dv_valid[0] = g_valid_ff;
   assign dv_stage[0] = g_stage_ff;

   for (genvar k = 0; k < ALPHA_W; k++) begin : g_div
      scmask_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .divisor   (cfg.len[DIVISOR_W-1:0]),
         .valid_in  (dv_valid[k]),
         .stage_in  (dv_stage[k]),
         .valid_out (dv_valid[k+1]),
         .stage_out (dv_stage[k+1])
      );
   end

   // Pick the settled value or the quotient.
   always_comb begin
      result.outside_mask = dv_stage[ALPHA_W].side.outside;
      result.alpha_value  = dv_stage[ALPHA_W].side.fixed ?
                            dv_stage[ALPHA_W].side.fixed_alpha : dv_stage[ALPHA_W].shift;
   end

   // Valid bits of the front and middle stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= sq_valid[ROOT_W];
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
      end
   end

   // Payload of the front and middle stages.
   always_ff @(posedge clock) begin
      if (en) begin
         a_req_ff     <= req_data;
         b_outside_ff <= b_outside_in;
         b_dx_ff      <= b_dx_in;
         b_dy_ff      <= b_dy_in;
         c_outside_ff <= b_outside_ff;
         c_dxsq_ff    <= c_dxsq_in;
         c_dysq_ff    <= c_dysq_in;
         d_stage_ff   <= d_stage_in;
         e_outside_ff <= sq_stage[ROOT_W].outside;
         e_inner_ff   <= e_inner_in;
         e_excess_ff  <= e_excess_in;
         f_side_ff    <= f_side_in;
         f_diff_ff    <= f_diff_in;
         g_stage_ff   <= g_stage_in;
      end
   end

   // Output register and skid entry.
   scmask_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid[ALPHA_W]),
      .in_data   (result),
      .advance   (en),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/core/scmask_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Soft circle alpha mask registers
// Configuration registers behind the APB port, plus a register stage that
// holds the saturated diameter, the soft start and the soft length.
// ---------------------------------------------------------------------------
module scmask_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [scmask_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [scmask_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [scmask_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                     pready,
   output scmask_pkg::cfg_type                      cfg
);
   import scmask_pkg::*;

   logic [DIAM_W-1:0]    diameter_ff, diameter_in;
   logic [SOFT_W-1:0]    softness_ff, softness_in;
   cfg_type              cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;
   logic [DIAM_W-1:0]    diam_sat;
   logic [SOFT_W-1:0]    soft_sat;
   logic [SOFT_W-1:0]    soft_comp;
   logic [START_W-1:0]   start_prod;
   logic [START_W-1:0]   soft_prod;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   // Register write decode.
   always_comb begin
      diameter_in = diameter_ff;
      softness_in = softness_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DIAMETER: diameter_in = pwdata[DIAM_W-1:0];
            REG_SOFTNESS: softness_in = pwdata[SOFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diameter_ff <= DIAM_RESET;
         softness_ff <= SOFT_RESET;
      end else begin
         diameter_ff <= diameter_in;
         softness_ff <= softness_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (reg_idx)
         REG_DIAMETER: prdata = CSR_DATA_W'(diameter_ff);
         REG_SOFTNESS: prdata = CSR_DATA_W'(softness_ff);
         default:      prdata = '0;
      endcase
   end

   // Saturate the registers and form the soft start and the soft length.
   always_comb begin
      diam_sat   = (diameter_ff > DIAM_W'(DIAM_LIMIT)) ? DIAM_W'(DIAM_LIMIT) : diameter_ff;
      soft_sat   = (softness_ff > SOFT_W'(SOFT_ONE)) ? SOFT_W'(SOFT_ONE) : softness_ff;
      soft_comp  = SOFT_W'(SOFT_ONE) - soft_sat;
      start_prod = START_W'(soft_comp) * START_W'(diam_sat);
      soft_prod  = START_W'(soft_sat) * START_W'(diam_sat);
      cfg_in.diameter = diam_sat;
      cfg_in.start    = start_prod;
      cfg_in.len      = $signed({1'b0, soft_prod}) - LEN_W'(SOFT_BIAS);
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### rtl/core/scmask_sqrt_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Soft circle alpha mask square root cell
// One digit step of a restoring integer square root: takes the next two
// radicand bits, decides one root bit and hands the result to the next cell.
// ---------------------------------------------------------------------------
module scmask_sqrt_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      valid_in,
   input  wire scmask_pkg::sq_stage_type  stage_in,
   output logic                           valid_out,
   output scmask_pkg::sq_stage_type       stage_out
);
   import scmask_pkg::*;

   logic         valid_ff;
   sq_stage_type stage_ff, stage_in_nx;
   logic [REM_W-1:0] pre;
   logic [REM_W-1:0] trial;
   logic             take;

   // Bring down two radicand bits and try the next root bit.
   always_comb begin
      pre   = {stage_in.rem[REM_W-3:0], stage_in.rad[RAD_W-1 -: 2]};
      trial = {stage_in.root, 2'b01};
      take  = (pre >= trial);
      stage_in_nx.outside = stage_in.outside;
      stage_in_nx.rad     = {stage_in.rad[RAD_W-3:0], 2'b00};
      stage_in_nx.rem     = take ? (pre - trial) : pre;
      stage_in_nx.root    = {stage_in.root[ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in_nx;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule
`default_nettype wire

### rtl/core/scmask_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Soft circle alpha mask division cell
// One step of a restoring division by the soft length: shifts in the next
// dividend bit, decides one quotient bit and hands the result on.
// ---------------------------------------------------------------------------
module scmask_div_cell (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic [scmask_pkg::DIVISOR_W-1:0]     divisor,
   input  wire logic                                 valid_in,
   input  wire scmask_pkg::div_stage_type            stage_in,
   output logic                                      valid_out,
   output scmask_pkg::div_stage_type                 stage_out
);
   import scmask_pkg::*;

   logic          valid_ff;
   div_stage_type stage_ff, stage_in_nx;
   logic [DIVISOR_W:0] pre;
   logic               take;

   // The partial remainder stays below the divisor after every step.
   always_comb begin
      pre  = {stage_in.part, stage_in.shift[ALPHA_W-1]};
      take = (pre >= {1'b0, divisor});
      stage_in_nx.side  = stage_in.side;
      stage_in_nx.part  = take ? DIVISOR_W'(pre - {1'b0, divisor}) : pre[DIVISOR_W-1:0];
      stage_in_nx.shift = {stage_in.shift[ALPHA_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in_nx;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule
`default_nettype wire

### rtl/core/scmask_out_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Soft circle alpha mask output buffer
// Output register with a skid entry behind it. The pipeline keeps moving
// while the skid entry is empty, so a stalled result never blocks new input
// until two results are waiting.
// ---------------------------------------------------------------------------
module scmask_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire scmask_pkg::rsp_type  in_data,
   output logic                      advance,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output scmask_pkg::rsp_type       rsp_data
);
   import scmask_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop     = out_valid_ff && rsp_ready;
   assign advance = !skid_valid_ff;

   // Refill the output register from the skid entry first, else from the
   // pipeline; park a new result in the skid entry while the output stalls.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !pop) begin
         if (in_valid) begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else begin
         out_valid_in = in_valid;
         out_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

### rtl/core/scmask_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Soft circle alpha mask checker
// Port-level checks of the output buffer, the result encoding and the
// register read back, bound to the top level.
// ---------------------------------------------------------------------------
module scmask_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_ready,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire scmask_pkg::rsp_type                 rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [scmask_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [scmask_pkg::CSR_DATA_W-1:0]   pwdata,
   input  wire logic [scmask_pkg::CSR_DATA_W-1:0]   prdata
);
   import scmask_pkg::*;

   // Reset leaves both sides empty and the input open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not empty or input closed after reset");

   // Input closes only while a result waits at the output.
   a_close_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input closed with no result waiting");

   // A stalled result holds its value.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // A position outside the mask is always transparent.
   a_outside_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outside_mask |-> rsp_data.alpha_value == ALPHA_CLEAR)
      else $error("outside position with nonzero alpha");

   // A diameter write reads back in the next cycle.
   a_diameter_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && (paddr[CSR_ADDR_W-1:2] == REG_DIAMETER))
      ##1 (paddr[CSR_ADDR_W-1:2] == REG_DIAMETER)
      |-> prdata == CSR_DATA_W'($past(pwdata[DIAM_W-1:0])))
      else $error("diameter read back differs from the written value");

endmodule

bind soft_circle_alpha_mask scmask_checker u_scmask_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata)
);
`default_nettype wire
